@@ src/rapq_pkg.sv @@
// Shared types and constants for the range-add / point-query segment tree core.
// No dependencies; used by rapq_tag_ram and range_add_point_query_tree_core.
package rapq_pkg;

    localparam int DATA_W        = 64;    // tag and sum width
    localparam int IN_POS_W      = 11;    // width of position fields on the ports
    localparam int POSITIONS_DEF = 1024;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_QWALK  = 6'b000100,
        ST_QLAST  = 6'b001000,
        ST_UVISIT = 6'b010000,
        ST_UWR    = 6'b100000
    } state_t;

endpackage

@@ src/rapq_tag_ram.sv @@
// Single write port, single registered read port tag memory.
// Depends on rapq_pkg for the data width.
module rapq_tag_ram #(
    parameter int DEPTH = 2 * rapq_pkg::POSITIONS_DEF
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [rapq_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [rapq_pkg::DATA_W-1:0] rd_data
);

    logic [rapq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rapq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/range_add_point_query_tree_core.sv @@
// Segment tree core: range add of a signed value, point query of the summed tags.
// Query: walks root to leaf, one tag read per level, summing the tags; in_ready and the
// result rise in the same cycle, unless the previous result is still held by out_ready.
// Add: visits nodes depth first, deferring right children on a stack, with a tag
// read-modify-write on each covered node; an empty range is dropped when accepted. One item at a time.
// Reset (rst_n, async low) starts a clearing pass over all 2*POSITIONS tags; in_ready low meanwhile.
module range_add_point_query_tree_core #(
    parameter int POSITIONS = rapq_pkg::POSITIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [rapq_pkg::IN_POS_W-1:0]      range_low,
    input  logic [rapq_pkg::IN_POS_W-1:0]      range_high,
    input  logic signed [rapq_pkg::DATA_W-1:0] add_value,
    input  logic [rapq_pkg::IN_POS_W-1:0]      position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rapq_pkg::DATA_W-1:0] point_sum
);

    localparam int DEPTH = 2 * POSITIONS;
    localparam int NW    = $clog2(DEPTH);
    localparam int PW0   = $clog2(POSITIONS + 1);
    localparam int PW    = (PW0 > rapq_pkg::IN_POS_W) ? PW0 : rapq_pkg::IN_POS_W;
    localparam int STK_D = $clog2(POSITIONS) + 1;
    localparam int SP_W  = $clog2(STK_D + 1);
    localparam int SI_W  = $clog2(STK_D);
    localparam int DW    = rapq_pkg::DATA_W;

    rapq_pkg::state_t state_reg, state_next;
    logic [NW-1:0]    clr_reg, clr_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic             out_valid_reg, out_valid_next;
    logic             pend_reg, pend_next;

    logic [NW-1:0]    node_reg, node_next;
    logic [PW-1:0]    lo_reg, lo_next;
    logic [PW-1:0]    hi_reg, hi_next;
    logic [PW-1:0]    a_reg, a_next;
    logic [PW-1:0]    b_reg, b_next;
    logic [DW-1:0]    value_reg, value_next;
    logic [DW-1:0]    sum_reg, sum_next;
    logic [DW-1:0]    point_sum_reg, point_sum_next;

    logic [NW-1:0]    stk_node [STK_D];
    logic [PW-1:0]    stk_lo   [STK_D];
    logic [PW-1:0]    stk_hi   [STK_D];

    logic             wr_en, rd_en, push_en;
    logic [NW-1:0]    wr_addr, rd_addr;
    logic [DW-1:0]    wr_data, rd_data;

    logic [PW-1:0]    mid, half_span, in_a, in_b, in_pos;
    logic [NW-1:0]    rnode;
    logic [SP_W-1:0]  sp_dec;
    logic             covered, leaf;
    logic [DW-1:0]    add_y;

    rapq_tag_ram #(
        .DEPTH(DEPTH)
    ) u_tag_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // child geometry of the current node
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign half_span = mid - lo_reg + PW'(1);
    assign rnode     = node_reg + (NW'(half_span) << 1);
    assign covered   = (a_reg <= lo_reg) && (hi_reg <= b_reg);
    assign leaf      = (lo_reg >= hi_reg);
    assign sp_dec    = sp_reg - SP_W'(1);

    // the one 64-bit adder: accumulates on queries, applies the add on updates
    assign add_y = rd_data + ((state_reg == rapq_pkg::ST_UWR) ? value_reg : sum_reg);

    always_comb
    begin
        in_a = PW'(range_low);
        if (in_a == '0)
        begin
            in_a = PW'(1);
        end
        in_b = PW'(range_high);
        if (in_b > PW'(POSITIONS))
        begin
            in_b = PW'(POSITIONS);
        end
        in_pos = PW'(position);
        if (in_pos == '0)
        begin
            in_pos = PW'(1);
        end
        else if (in_pos > PW'(POSITIONS))
        begin
            in_pos = PW'(POSITIONS);
        end
    end

    assign in_ready = (state_reg == rapq_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sp_next        = sp_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        value_next     = value_reg;
        sum_next       = sum_reg;
        point_sum_next = point_sum_reg;
        wr_en          = 1'b0;
        wr_addr        = node_reg;
        wr_data        = add_y;
        rd_en          = 1'b0;
        rd_addr        = node_reg;
        push_en        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rapq_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + NW'(1);
                if (clr_reg == NW'(DEPTH - 1))
                begin
                    state_next = rapq_pkg::ST_IDLE;
                end
            end
            rapq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    node_next = '0;
                    lo_next   = PW'(1);
                    hi_next   = PW'(POSITIONS);
                    if (cmd == rapq_pkg::CMD_QUERY)
                    begin
                        a_next     = in_pos;
                        sum_next   = '0;
                        pend_next  = 1'b0;
                        state_next = rapq_pkg::ST_QWALK;
                    end
                    else if (in_a <= in_b)
                    begin
                        a_next     = in_a;
                        b_next     = in_b;
                        value_next = add_value;
                        sp_next    = '0;
                        state_next = rapq_pkg::ST_UVISIT;
                    end
                end
            end
            rapq_pkg::ST_QWALK:
            begin
                // a_reg holds the query position; reads stream one level per cycle
                rd_en     = 1'b1;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    sum_next = add_y;
                end
                if (leaf)
                begin
                    state_next = rapq_pkg::ST_QLAST;
                end
                else if (a_reg <= mid)
                begin
                    node_next = node_reg + NW'(1);
                    hi_next   = mid;
                end
                else
                begin
                    node_next = rnode;
                    lo_next   = mid + PW'(1);
                end
            end
            rapq_pkg::ST_QLAST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    point_sum_next = add_y;
                    out_valid_next = 1'b1;
                    state_next     = rapq_pkg::ST_IDLE;
                end
            end
            rapq_pkg::ST_UVISIT:
            begin
                if (covered)
                begin
                    rd_en      = 1'b1;
                    state_next = rapq_pkg::ST_UWR;
                end
                else if (leaf)
                begin
                    if (sp_reg == '0)
                    begin
                        state_next = rapq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        node_next = stk_node[sp_dec[SI_W-1:0]];
                        lo_next   = stk_lo[sp_dec[SI_W-1:0]];
                        hi_next   = stk_hi[sp_dec[SI_W-1:0]];
                        sp_next   = sp_dec;
                    end
                end
                else if (a_reg <= mid)
                begin
                    // defer the right child when the range reaches it too
                    if (b_reg > mid)
                    begin
                        push_en = 1'b1;
                        sp_next = sp_reg + SP_W'(1);
                    end
                    node_next = node_reg + NW'(1);
                    hi_next   = mid;
                end
                else
                begin
                    node_next = rnode;
                    lo_next   = mid + PW'(1);
                end
            end
            rapq_pkg::ST_UWR:
            begin
                wr_en = 1'b1;
                if (sp_reg == '0)
                begin
                    state_next = rapq_pkg::ST_IDLE;
                end
                else
                begin
                    node_next  = stk_node[sp_dec[SI_W-1:0]];
                    lo_next    = stk_lo[sp_dec[SI_W-1:0]];
                    hi_next    = stk_hi[sp_dec[SI_W-1:0]];
                    sp_next    = sp_dec;
                    state_next = rapq_pkg::ST_UVISIT;
                end
            end
            default:
            begin
                state_next = rapq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rapq_pkg::ST_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        value_reg     <= value_next;
        sum_reg       <= sum_next;
        point_sum_reg <= point_sum_next;
        if (push_en)
        begin
            stk_node[sp_reg[SI_W-1:0]] <= rnode;
            stk_lo[sp_reg[SI_W-1:0]]   <= mid + PW'(1);
            stk_hi[sp_reg[SI_W-1:0]]   <= hi_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_sum = point_sum_reg;

`ifndef NO_ASSERTIONS
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("tag RAM read and write in the same cycle");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STK_D))
        else $error("walk stack overflow");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rapq_pkg::ST_QWALK || state_reg == rapq_pkg::ST_UVISIT)
        |-> lo_reg <= hi_reg)
        else $error("node interval inverted");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rapq_pkg::ST_QLAST)
        else $error("result transaction not produced by a query");
`endif

endmodule

@@ test/range_add_point_query_tree_core_test.sv @@
// Testbench for range_add_point_query_tree_core: directed and random range adds and
// point queries, checked against a per-position running-total predictor.
// Depends on rapq_pkg and range_add_point_query_tree_core.
module range_add_point_query_tree_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  POSITIONS   = rapq_pkg::POSITIONS_DEF;
    localparam int  HALF_PERIOD = 10;
    localparam int  STALL_LIMIT = 20000;  // covers the post-reset clearing pass
    localparam int  TAIL_CYCLES = 200;    // longer than the slowest add walk

    typedef struct packed {
        logic                               cmd;
        logic [rapq_pkg::IN_POS_W-1:0]      lo;
        logic [rapq_pkg::IN_POS_W-1:0]      hi;
        logic signed [rapq_pkg::DATA_W-1:0] value;
        logic [rapq_pkg::IN_POS_W-1:0]      pos;
    } tree_op_t;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               cmd;
    logic [rapq_pkg::IN_POS_W-1:0]      range_low;
    logic [rapq_pkg::IN_POS_W-1:0]      range_high;
    logic signed [rapq_pkg::DATA_W-1:0] add_value;
    logic [rapq_pkg::IN_POS_W-1:0]      position;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [rapq_pkg::DATA_W-1:0] point_sum;

    // running total per position; wraps modulo 2^64
    logic [rapq_pkg::DATA_W-1:0]  point_totals [1:POSITIONS];
    logic [rapq_pkg::DATA_W-1:0]  expected_sums [$];

    bit  steady;
    int  errors;
    int  adds_sent;
    int  empty_adds;
    int  queries_sent;
    int  sums_checked;
    int  quiet_cycles;

    range_add_point_query_tree_core #(
        .POSITIONS (POSITIONS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .range_low  (range_low),
        .range_high (range_high),
        .add_value  (add_value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_sum  (point_sum)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_ready = steady || ($urandom_range(99) >= 13);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected point_sum transaction: expected none, actual %h",
                         $time, point_sum);
            end
            else
            begin
                logic [rapq_pkg::DATA_W-1:0] want;
                want = expected_sums.pop_front();
                if (point_sum !== want)
                begin
                    errors++;
                    $display("%0t: point_sum mismatch: expected %h, actual %h",
                             $time, want, point_sum);
                end
            end
            sums_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("range_add_point_query_tree_core_test: done, errors");
            $finish;
        end
    end

    task automatic track_accepted(input tree_op_t op);
        int lo_c;
        int hi_c;
        int p;
        if (op.cmd == rapq_pkg::CMD_ADD)
        begin
            lo_c = (op.lo < 1) ? 1 : int'(op.lo);
            hi_c = (op.hi > POSITIONS) ? POSITIONS : int'(op.hi);
            adds_sent++;
            if (lo_c > hi_c)
                empty_adds++;
            for (p = lo_c; p <= hi_c; p++)
                point_totals[p] = point_totals[p] + op.value;
        end
        else
        begin
            p = (op.pos < 1) ? 1 : ((op.pos > POSITIONS) ? POSITIONS : int'(op.pos));
            queries_sent++;
            expected_sums = {expected_sums, point_totals[p]};
        end
    endtask

    task automatic send_item(input tree_op_t op);
        int gap_len;
        if (!steady && $urandom_range(99) < 13)
        begin
            in_valid = 1'b0;
            gap_len = $urandom_range(4, 1);
            repeat (gap_len) @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = op.cmd;
        range_low  = op.lo;
        range_high = op.hi;
        add_value  = op.value;
        position   = op.pos;
        do
            @(posedge clk);
        while (!in_ready);
        track_accepted(op);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [rapq_pkg::DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // unused fields carry random junk
    task automatic send_add(input int lo, input int hi,
                            input logic [rapq_pkg::DATA_W-1:0] value);
        tree_op_t op;
        op.cmd   = rapq_pkg::CMD_ADD;
        op.lo    = rapq_pkg::IN_POS_W'(lo);
        op.hi    = rapq_pkg::IN_POS_W'(hi);
        op.value = value;
        op.pos   = rapq_pkg::IN_POS_W'($urandom_range(2047));
        send_item(op);
    endtask

    task automatic send_query(input int pos);
        tree_op_t op;
        op.cmd   = rapq_pkg::CMD_QUERY;
        op.lo    = rapq_pkg::IN_POS_W'($urandom_range(2047));
        op.hi    = rapq_pkg::IN_POS_W'($urandom_range(2047));
        op.value = random_word();
        op.pos   = rapq_pkg::IN_POS_W'(pos);
        send_item(op);
    endtask

    task automatic wait_drained();
        while (expected_sums.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        send_query(1);
        send_query(POSITIONS);
        send_add(1, POSITIONS, 64'h7fff_ffff_ffff_ffff);
        send_add(0, 2047, 64'h0000_0000_0000_0002);      // both ends clamp, sum wraps
        send_add(600, 500, random_word());                // empty range
        send_add(1500, 2047, random_word());              // starts past the last position
        send_add(1, 1, 64'h8000_0000_0000_0000);
        send_add(POSITIONS, POSITIONS, 64'hffff_ffff_ffff_ffff);
        send_add(POSITIONS / 2, POSITIONS / 2 + 1, 64'h0000_0000_0000_0123);
        send_add(2, POSITIONS - 1, 64'h8000_0000_0000_0000);
        send_query(0);
        send_query(1);
        send_query(2);
        send_query(POSITIONS / 2);
        send_query(POSITIONS / 2 + 1);
        send_query(POSITIONS - 1);
        send_query(POSITIONS);
        send_query(POSITIONS + 1);
        send_query(2047);
        send_add(POSITIONS + 1, POSITIONS + 1, random_word());
        send_add(0, 0, random_word());
        send_query(1);
        send_query(POSITIONS);
    endtask

    task automatic test_random_mix(input int count);
        int i;
        int lo;
        int hi;
        int shape;
        logic [rapq_pkg::DATA_W-1:0] value;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 45)
            begin
                if ($urandom_range(9) == 0)
                    send_query($urandom_range(2047));
                else
                    send_query($urandom_range(POSITIONS, 1));
            end
            else
            begin
                shape = $urandom_range(9);
                if (shape == 0)
                begin
                    lo = $urandom_range(2047);
                    hi = $urandom_range(2047);
                end
                else if (shape <= 4)
                begin
                    lo = $urandom_range(POSITIONS, 1);
                    hi = lo + $urandom_range(15);
                end
                else if (shape <= 7)
                begin
                    lo = $urandom_range(POSITIONS, 1);
                    hi = $urandom_range(POSITIONS, lo);
                end
                else
                begin
                    lo = $urandom_range(8, 1);
                    hi = $urandom_range(POSITIONS, POSITIONS - 8);
                end
                if ($urandom_range(1))
                    value = random_word();
                else
                    value = longint'($urandom_range(2000)) - 1000;
                send_add(lo, hi, value);
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        steady = 1'b1;
        test_random_mix(count);
        wait_drained();
        steady = 1'b0;
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = rapq_pkg::CMD_ADD;
        range_low  = '0;
        range_high = '0;
        add_value  = '0;
        position   = '0;
        out_ready  = 1'b1;
        steady     = 1'b0;
        errors     = 0;
        quiet_cycles = 0;
        for (int p = 1; p <= POSITIONS; p++)
            point_totals[p] = '0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        wait_drained();
        test_random_mix(700);
        wait_drained();
        test_back_to_back(300);
        test_random_mix(380);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d adds (%0d empty after clamping) and %0d queries;",
                 adds_sent, empty_adds, queries_sent);
        $display("%0d sums compared, %0d still outstanding", sums_checked,
                 expected_sums.size());
        if (errors == 0 && expected_sums.size() == 0)
            $display("range_add_point_query_tree_core_test: done, clean");
        else
            $display("range_add_point_query_tree_core_test: done, errors");
        $finish;
    end

endmodule
